// ----- rtl/acor_pkg.sv -----
// shared constants and types for the oldest-replace associative tag table
`default_nettype none

package acor_pkg;

    // table geometry
    localparam int ENTRIES = 128;
    localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W   = $clog2(ENTRIES + 1);

    // field widths
    localparam int CFG_W   = 8;
    localparam int KEY_W   = 32;
    localparam int LEN_W   = 31;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 7;

    // width used to clamp the entry count register against the table size
    localparam int CMP_W   = (CNT_W > CFG_W) ? CNT_W : CFG_W;

    // one stored row: key, length, stamp
    localparam int ROW_W   = KEY_W + LEN_W + STAMP_W;

    // reset values
    localparam logic [CFG_W-1:0]   CFG_RESET  = CFG_W'(128);
    localparam logic [STAMP_W-1:0] STAMP_INIT = STAMP_W'(1);
    localparam logic [STAMP_W-1:0] STAMP_MAX  = '1;

    // request kinds
    localparam logic MODE_LOOKUP = 1'b0;
    localparam logic MODE_INSERT = 1'b1;

    // stored row layout
    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [LEN_W-1:0]   length;
        logic [STAMP_W-1:0] stamp;
    } row_t;

endpackage

`default_nettype wire

// ----- rtl/acor_ram.sv -----
// generic single write port ram with registered read
`default_nettype none

module acor_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                      wr_data,
    input  wire logic                                  rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                      rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ----- rtl/assoc_cache_oldest_replace_top.sv -----
// fully associative tag table with oldest-inserted replacement
//
// Each request is a lookup (mode 0) or an insert (mode 1). The block walks
// entries 0 .. n-1 through one dual-port row ram, one row read per cycle,
// where n is entries_in_use clamped to 1 .. ENTRIES. A lookup returns the
// lowest valid entry with an equal key and its stored length, or a miss with
// slot and length zero. An insert overwrites the entry with the smallest
// insertion stamp (lowest index on a tie) and returns its slot; hits never
// refresh stamps. A request is accepted, then the n row reads run with a
// final compare after the last one, an insert then writes its row to the
// ram, and the result register is loaded once it is free. The next request
// can be taken as soon as the result is offered. The block takes no new
// request while one is in progress, but it accepts the next one while a
// finished result waits to be taken.
// Valid bits live in flip-flops cleared by reset, so no clearing pass is
// needed. Write entries_in_use only while the block is idle.
`default_nettype none

module assoc_cache_oldest_replace_top (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,

    // configuration
    input  wire logic                          cfg_wr_en,
    input  wire logic [acor_pkg::CFG_W-1:0]    cfg_wr_data,

    // request channel
    input  wire logic                          s_valid,
    output logic                               s_ready,
    input  wire logic                          s_mode,
    input  wire logic [acor_pkg::KEY_W-1:0]    s_key,
    input  wire logic [acor_pkg::LEN_W-1:0]    s_length,

    // result channel
    output logic                               m_valid,
    input  wire logic                          m_ready,
    output logic                               m_hit,
    output logic [acor_pkg::SLOT_W-1:0]        m_slot,
    output logic [acor_pkg::LEN_W-1:0]         m_stored_length
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    // control state
    state_t                           state_reg, state_next;
    logic [acor_pkg::CFG_W-1:0]       cfg_reg, cfg_next;
    logic [acor_pkg::ENTRIES-1:0]     valid_reg, valid_next;
    logic [acor_pkg::STAMP_W-1:0]     next_stamp_reg, next_stamp_next;
    logic [acor_pkg::CNT_W-1:0]       issue_cnt_reg, issue_cnt_next;
    logic                             rd_pend_reg, rd_pend_next;
    logic                             found_reg, found_next;
    logic                             m_valid_reg, m_valid_next;

    // payload
    logic                             req_mode_reg, req_mode_next;
    logic [acor_pkg::KEY_W-1:0]       req_key_reg, req_key_next;
    logic [acor_pkg::LEN_W-1:0]       req_len_reg, req_len_next;
    logic [acor_pkg::IDX_W-1:0]       rd_idx_reg, rd_idx_next;
    logic [acor_pkg::IDX_W-1:0]       best_idx_reg, best_idx_next;
    logic [acor_pkg::STAMP_W-1:0]     best_stamp_reg, best_stamp_next;
    logic [acor_pkg::LEN_W-1:0]       match_len_reg, match_len_next;
    logic                             m_hit_reg, m_hit_next;
    logic [acor_pkg::SLOT_W-1:0]      m_slot_reg, m_slot_next;
    logic [acor_pkg::LEN_W-1:0]       m_len_reg, m_len_next;

    // ram ports
    logic                             ram_wr_en;
    logic                             ram_rd_en;
    logic [acor_pkg::IDX_W-1:0]       ram_rd_addr;
    acor_pkg::row_t                   ram_wr_row;
    acor_pkg::row_t                   ram_rd_row;

    // clamped entry count
    logic [acor_pkg::CMP_W-1:0]       cfg_wide;
    logic [acor_pkg::CNT_W-1:0]       active_n;

    // compare unit
    logic                             row_valid;
    logic [acor_pkg::STAMP_W-1:0]     row_stamp;
    logic                             key_eq;
    logic                             stamp_lt;

    // entries_in_use of zero acts as one, above the table size as the table size
    always_comb begin
        cfg_wide = acor_pkg::CMP_W'(cfg_reg);
        if (cfg_wide == '0) begin
            active_n = acor_pkg::CNT_W'(1);
        end else if (cfg_wide > acor_pkg::CMP_W'(acor_pkg::ENTRIES)) begin
            active_n = acor_pkg::CNT_W'(acor_pkg::ENTRIES);
        end else begin
            active_n = acor_pkg::CNT_W'(cfg_wide);
        end
    end

    // row storage: key, length and stamp of every entry
    acor_ram #(
        .WIDTH (acor_pkg::ROW_W),
        .DEPTH (acor_pkg::ENTRIES)
    ) u_row_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (best_idx_reg),
        .wr_data (ram_wr_row),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_row)
    );

    // shared compare on the row just read; unwritten entries have stamp zero
    always_comb begin
        row_valid = valid_reg[rd_idx_reg];
        row_stamp = row_valid ? ram_rd_row.stamp : '0;
        key_eq    = row_valid && (ram_rd_row.key == req_key_reg);
        stamp_lt  = (row_stamp < best_stamp_reg);
    end

    // sequencer
    always_comb begin
        state_next      = state_reg;
        cfg_next        = cfg_reg;
        valid_next      = valid_reg;
        next_stamp_next = next_stamp_reg;
        issue_cnt_next  = issue_cnt_reg;
        rd_pend_next    = 1'b0;
        found_next      = found_reg;
        m_valid_next    = m_valid_reg;
        req_mode_next   = req_mode_reg;
        req_key_next    = req_key_reg;
        req_len_next    = req_len_reg;
        rd_idx_next     = rd_idx_reg;
        best_idx_next   = best_idx_reg;
        best_stamp_next = best_stamp_reg;
        match_len_next  = match_len_reg;
        m_hit_next      = m_hit_reg;
        m_slot_next     = m_slot_reg;
        m_len_next      = m_len_reg;
        ram_wr_en       = 1'b0;
        ram_rd_en       = 1'b0;
        ram_rd_addr     = issue_cnt_reg[acor_pkg::IDX_W-1:0];
        ram_wr_row      = '{key: req_key_reg, length: req_len_reg, stamp: next_stamp_reg};

        // configuration write
        if (cfg_wr_en) begin
            cfg_next = cfg_wr_data;
        end

        // result taken
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    req_mode_next   = s_mode;
                    req_key_next    = s_key;
                    req_len_next    = s_length;
                    issue_cnt_next  = '0;
                    found_next      = 1'b0;
                    best_idx_next   = '0;
                    best_stamp_next = '0;
                    match_len_next  = '0;
                    state_next      = ST_SCAN;
                end
            end

            ST_SCAN: begin
                // issue the next row read
                if (issue_cnt_reg < active_n) begin
                    ram_rd_en      = 1'b1;
                    rd_pend_next   = 1'b1;
                    rd_idx_next    = issue_cnt_reg[acor_pkg::IDX_W-1:0];
                    issue_cnt_next = issue_cnt_reg + acor_pkg::CNT_W'(1);
                end else if (req_mode_reg == acor_pkg::MODE_INSERT) begin
                    state_next = ST_WRITE;
                end else begin
                    state_next = ST_FINISH;
                end

                // compare the row read last cycle
                if (rd_pend_reg) begin
                    if (req_mode_reg == acor_pkg::MODE_LOOKUP) begin
                        if (!found_reg && key_eq) begin
                            found_next     = 1'b1;
                            best_idx_next  = rd_idx_reg;
                            match_len_next = ram_rd_row.length;
                        end
                    end else if ((rd_idx_reg == '0) || stamp_lt) begin
                        best_idx_next   = rd_idx_reg;
                        best_stamp_next = row_stamp;
                    end
                end
            end

            ST_WRITE: begin
                // overwrite the oldest entry and step the stamp counter
                ram_wr_en                = 1'b1;
                valid_next[best_idx_reg] = 1'b1;
                if (next_stamp_reg != acor_pkg::STAMP_MAX) begin
                    next_stamp_next = next_stamp_reg + acor_pkg::STAMP_W'(1);
                end
                state_next = ST_FINISH;
            end

            ST_FINISH: begin
                // load the result once the output register is free
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_hit_next   = found_reg;
                    m_slot_next  = acor_pkg::SLOT_W'(best_idx_reg);
                    m_len_next   = match_len_reg;
                    state_next   = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            cfg_reg        <= acor_pkg::CFG_RESET;
            valid_reg      <= '0;
            next_stamp_reg <= acor_pkg::STAMP_INIT;
            issue_cnt_reg  <= '0;
            rd_pend_reg    <= 1'b0;
            found_reg      <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            cfg_reg        <= cfg_next;
            valid_reg      <= valid_next;
            next_stamp_reg <= next_stamp_next;
            issue_cnt_reg  <= issue_cnt_next;
            rd_pend_reg    <= rd_pend_next;
            found_reg      <= found_next;
            m_valid_reg    <= m_valid_next;
        end
        req_mode_reg   <= req_mode_next;
        req_key_reg    <= req_key_next;
        req_len_reg    <= req_len_next;
        rd_idx_reg     <= rd_idx_next;
        best_idx_reg   <= best_idx_next;
        best_stamp_reg <= best_stamp_next;
        match_len_reg  <= match_len_next;
        m_hit_reg      <= m_hit_next;
        m_slot_reg     <= m_slot_next;
        m_len_reg      <= m_len_next;
    end

    // ports
    assign s_ready         = (state_reg == ST_IDLE);
    assign m_valid         = m_valid_reg;
    assign m_hit           = m_hit_reg;
    assign m_slot          = m_slot_reg;
    assign m_stored_length = m_len_reg;

endmodule

`default_nettype wire
